// ===== rtl/voice_slot_allocator_macros.svh =====
// Assertion helpers for the voice slot allocator checkers.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef VOICE_SLOT_ALLOCATOR_MACROS_SVH
`define VOICE_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define VSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("voice slot allocator check failed");

// Next-cycle implication.
`define VSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("voice slot allocator check failed");

`endif

// ===== rtl/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and constants of the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int SRC_FIELD_W  = 6;
  localparam int LOUD_W       = 17;
  localparam int FUNC_W       = 3;
  localparam int SLOT_FIELD_W = 5;
  localparam int CFG_W        = 6;
  localparam int QDEPTH       = 2;

  localparam logic [LOUD_W-1:0]  LOUD_ONE  = 17'h10000;
  localparam logic [FUNC_W-1:0]  FUNC_NONE = 3'd7;
  localparam logic [CFG_W-1:0]   SLOTS_AVAIL_RST = 6'd32;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_RETIRE  = 2'd2,
    ACT_ASSIGN  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_IGNORE,
    KIND_SILENT,
    KIND_SOUND
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_DECIDE,
    ST_SECOND
  } state_e;

  typedef struct packed {
    kind_e                  kind;
    logic [SRC_FIELD_W-1:0] src;
    logic [LOUD_W-1:0]      loud;
    logic [FUNC_W-1:0]      func;
  } item_t;

  typedef struct packed {
    action_e                 action;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [SRC_FIELD_W-1:0]  source;
    logic [FUNC_W-1:0]       func;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// voice_slot_allocator
// Maps logical sound sources onto a pool of hardware voice slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one event request: source,
//   loudness (unsigned Q1.16, 1.0 = 65536, larger values saturate) and command.
//   Output channel (out_valid_o/out_ready_i) returns one or two results per
//   event; last_o marks the final one. An eviction gives a retire of the
//   quietest occupant followed by an assign of the new source to that slot.
//   cfg_we_i/cfg_wdata_i write slots_available; write it only while idle.
// Timing:
//   Silent, out-of-range and already playing events pass the idle and look
//   states to the result register. A new source scans the slots through the
//   owner and loudness memories, one per cycle, then enters the decide state;
//   an eviction's assign follows its retire from the second state. The serial
//   scan sets the throughput. A two-entry queue takes requests meanwhile.
// Reset:
//   All sources unassigned, all slots free, slots_available = 32.
//   When out_ready_i is low the pending result holds and the back end stalls;
//   requests keep queueing until the queue is full.
// ----------------------------------------------------------------------------
module voice_slot_allocator #(
  parameter int NUM_SLOTS   = 32,
  parameter int NUM_SOURCES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [vsa_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [vsa_pkg::SRC_FIELD_W-1:0]    source_index_i,
  input  logic [vsa_pkg::LOUD_W-1:0]         loudness_i,
  input  logic [vsa_pkg::FUNC_W-1:0]         func_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         action_o,
  output logic [vsa_pkg::SLOT_FIELD_W-1:0]   slot_o,
  output logic [vsa_pkg::SRC_FIELD_W-1:0]    source_o,
  output logic [vsa_pkg::FUNC_W-1:0]         forwarded_func_o,
  output logic                               last_o
);
  import vsa_pkg::*;

  logic [CFG_W-1:0] slots_avail_q;
  qstat_t           qstat;
  logic             push;
  logic             pop;
  item_t            push_item;
  item_t            head_item;
  result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_avail_q <= SLOTS_AVAIL_RST;
    end else if (cfg_we_i) begin
      slots_avail_q <= cfg_wdata_i;
    end
  end

  vsa_front #(.NUM_SOURCES(NUM_SOURCES)) u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .source_index_i (source_index_i),
    .loudness_i     (loudness_i),
    .func_i         (func_i),
    .qstat_i        (qstat),
    .push_o         (push),
    .item_o         (push_item)
  );

  vsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  vsa_back #(.NUM_SLOTS(NUM_SLOTS), .NUM_SOURCES(NUM_SOURCES)) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .slots_available_i (slots_avail_q),
    .qstat_i           (qstat),
    .item_i            (head_item),
    .pop_o             (pop),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .result_o          (result)
  );

  assign action_o         = result.action;
  assign slot_o           = result.slot;
  assign source_o         = result.source;
  assign forwarded_func_o = result.func;
  assign last_o           = result.last;

endmodule

// ===== rtl/vsa_ram.sv =====
// ----------------------------------------------------------------------------
// vsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/vsa_fifo.sv =====
// ----------------------------------------------------------------------------
// vsa_fifo
// Short request queue between the front and the back of the allocator.
// ----------------------------------------------------------------------------
module vsa_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vsa_pkg::item_t item_i,
  input  logic           pop_i,
  output vsa_pkg::item_t item_o,
  output vsa_pkg::qstat_t qstat_o
);
  import vsa_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  item_t             mem_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = PTR_W'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = PTR_W'(rd_ptr_q + 1'b1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = CNT_W'(cnt_q + 1'b1);
      2'b01:   cnt_d = CNT_W'(cnt_q - 1'b1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

// ===== rtl/vsa_front.sv =====
// ----------------------------------------------------------------------------
// vsa_front
// Accepts event requests, saturates loudness and sorts them into ignored,
// silent and sounding events before they enter the queue.
// ----------------------------------------------------------------------------
module vsa_front #(
  parameter int NUM_SOURCES = 64
) (
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [vsa_pkg::SRC_FIELD_W-1:0]    source_index_i,
  input  logic [vsa_pkg::LOUD_W-1:0]         loudness_i,
  input  logic [vsa_pkg::FUNC_W-1:0]         func_i,
  input  vsa_pkg::qstat_t                    qstat_i,
  output logic                               push_o,
  output vsa_pkg::item_t                     item_o
);
  import vsa_pkg::*;

  logic              in_range;
  logic [LOUD_W-1:0] loud_sat;

  assign in_range   = (32'(source_index_i) < NUM_SOURCES);
  assign loud_sat   = (loudness_i > LOUD_ONE) ? LOUD_ONE : loudness_i;
  assign in_ready_o = !qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  always_comb begin
    item_o.src  = source_index_i;
    item_o.loud = loud_sat;
    item_o.func = func_i;
    if (!in_range) begin
      item_o.kind = KIND_IGNORE;
    end else if (loud_sat == '0) begin
      item_o.kind = KIND_SILENT;
    end else begin
      item_o.kind = KIND_SOUND;
    end
  end

endmodule

// ===== rtl/vsa_back.sv =====
// ----------------------------------------------------------------------------
// vsa_back
// Carries out queued events: keeps the loudness, source and slot stores,
// scans the slots for a free or the quietest entry and drives the results.
// ----------------------------------------------------------------------------
module vsa_back #(
  parameter int NUM_SLOTS   = 32,
  parameter int NUM_SOURCES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [vsa_pkg::CFG_W-1:0]  slots_available_i,
  input  vsa_pkg::qstat_t            qstat_i,
  input  vsa_pkg::item_t             item_i,
  output logic                       pop_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output vsa_pkg::result_t           result_o
);
  import vsa_pkg::*;

  localparam int NSRC   = (NUM_SOURCES < 64) ? NUM_SOURCES : 64;
  localparam int SRC_W  = (NSRC > 1) ? $clog2(NSRC) : 1;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int UW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  function automatic logic [SLOT_FIELD_W-1:0] slot_out(logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOT_FIELD_W-1:0] w;
    w = {{SLOT_FIELD_W{1'b0}}, s};
    return w[SLOT_FIELD_W-1:0];
  endfunction

  function automatic logic [SRC_FIELD_W-1:0] src_out(logic [SRC_W-1:0] s);
    logic [SRC_W+SRC_FIELD_W-1:0] w;
    w = {{SRC_FIELD_W{1'b0}}, s};
    return w[SRC_FIELD_W-1:0];
  endfunction

  state_e             state_q, state_d;
  item_t              cur_q, cur_d;
  logic [NSRC-1:0]    src_valid_q, src_valid_d;
  logic [NUM_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [CNT_W-1:0]   in_use_q, in_use_d;
  logic               faint_mode_q, faint_mode_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               a_vld_q, a_vld_d, a_used_q, a_used_d;
  logic [SLOT_W-1:0]  a_idx_q, a_idx_d;
  logic               b_vld_q, b_vld_d, b_used_q, b_used_d;
  logic [SLOT_W-1:0]  b_idx_q, b_idx_d;
  logic [SRC_W-1:0]   b_owner_q, b_owner_d;
  logic               found_q, found_d;
  logic [SLOT_W-1:0]  pick_slot_q, pick_slot_d;
  logic [SRC_W-1:0]   pick_owner_q, pick_owner_d;
  logic [LOUD_W-1:0]  fv_q, fv_d;
  logic               out_vld_q, out_vld_d;
  result_t            res_q, res_d;

  logic [UW-1:0]      avail_w;
  logic [CNT_W-1:0]   usable;
  logic [SRC_W-1:0]   cur_src;
  logic               can_emit;
  logic               issue;
  logic               take;

  logic               loud_we;
  logic [LOUD_W-1:0]  loud_rdata;
  logic               sos_we;
  logic [SLOT_W-1:0]  sos_rdata;
  logic               own_we;
  logic [SRC_W-1:0]   own_rdata;

  assign avail_w  = UW'(slots_available_i);
  assign usable   = (avail_w < UW'(NUM_SLOTS)) ? CNT_W'(avail_w) : CNT_W'(NUM_SLOTS);
  assign cur_src  = cur_q.src[SRC_W-1:0];
  assign can_emit = !out_vld_q || out_ready_i;
  assign issue    = (state_q == ST_SCAN) && (cnt_q < usable);
  assign loud_we  = pop_o && (item_i.kind != KIND_IGNORE);

  // per-source loudness
  vsa_ram #(.WIDTH(LOUD_W), .DEPTH(NSRC)) u_loud_ram (
    .clk_i   (clk_i),
    .we_i    (loud_we),
    .waddr_i (item_i.src[SRC_W-1:0]),
    .wdata_i (item_i.loud),
    .re_i    (a_vld_q),
    .raddr_i (own_rdata),
    .rdata_o (loud_rdata)
  );

  // slot held by each source
  vsa_ram #(.WIDTH(SLOT_W), .DEPTH(NSRC)) u_sos_ram (
    .clk_i   (clk_i),
    .we_i    (sos_we),
    .waddr_i (cur_src),
    .wdata_i (pick_slot_q),
    .re_i    (pop_o),
    .raddr_i (item_i.src[SRC_W-1:0]),
    .rdata_o (sos_rdata)
  );

  // source owning each slot
  vsa_ram #(.WIDTH(SRC_W), .DEPTH(NUM_SLOTS)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (pick_slot_q),
    .wdata_i (cur_src),
    .re_i    (issue),
    .raddr_i (cnt_q[SLOT_W-1:0]),
    .rdata_o (own_rdata)
  );

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    src_valid_d  = src_valid_q;
    slot_valid_d = slot_valid_q;
    in_use_d     = in_use_q;
    faint_mode_d = faint_mode_q;
    cnt_d        = cnt_q;
    a_vld_d      = 1'b0;
    a_used_d     = a_used_q;
    a_idx_d      = a_idx_q;
    b_vld_d      = a_vld_q;
    b_used_d     = a_used_q;
    b_idx_d      = a_idx_q;
    b_owner_d    = own_rdata;
    found_d      = found_q;
    pick_slot_d  = pick_slot_q;
    pick_owner_d = pick_owner_q;
    fv_d         = fv_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    res_d        = res_q;
    pop_o        = 1'b0;
    sos_we       = 1'b0;
    own_we       = 1'b0;
    take         = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (!qstat_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = item_i;
          state_d = ST_LOOK;
        end
      end

      ST_LOOK: begin
        unique case (cur_q.kind)
          KIND_SOUND: begin
            if (src_valid_q[cur_src]) begin
              if (can_emit) begin
                out_vld_d = 1'b1;
                if (cur_q.func == FUNC_NONE) begin
                  res_d = '{ACT_NONE, '0, '0, '0, 1'b1};
                end else begin
                  res_d = '{ACT_FORWARD, slot_out(sos_rdata), src_out(cur_src),
                            cur_q.func, 1'b1};
                end
                state_d = ST_IDLE;
              end
            end else begin
              cnt_d        = '0;
              found_d      = 1'b0;
              fv_d         = LOUD_ONE;
              faint_mode_d = (in_use_q >= usable);
              state_d      = ST_SCAN;
            end
          end
          KIND_SILENT: begin
            if (can_emit) begin
              out_vld_d = 1'b1;
              if (src_valid_q[cur_src]) begin
                res_d = '{ACT_RETIRE, slot_out(sos_rdata), src_out(cur_src), '0, 1'b1};
                src_valid_d[cur_src]    = 1'b0;
                slot_valid_d[sos_rdata] = 1'b0;
                if (in_use_q != '0) begin
                  in_use_d = CNT_W'(in_use_q - 1'b1);
                end
              end else begin
                res_d = '{ACT_NONE, '0, '0, '0, 1'b1};
              end
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (can_emit) begin
              out_vld_d = 1'b1;
              res_d     = '{ACT_NONE, '0, '0, '0, 1'b1};
              state_d   = ST_IDLE;
            end
          end
        endcase
      end

      ST_SCAN: begin
        // one slot enters the two-stage read pipe per cycle
        if (issue) begin
          cnt_d    = CNT_W'(cnt_q + 1'b1);
          a_vld_d  = 1'b1;
          a_used_d = slot_valid_q[cnt_q[SLOT_W-1:0]];
          a_idx_d  = cnt_q[SLOT_W-1:0];
        end
        if (b_vld_q) begin
          if (faint_mode_q) begin
            if (b_used_q && (loud_rdata < fv_q)) begin
              fv_d         = loud_rdata;
              pick_slot_d  = b_idx_q;
              pick_owner_d = b_owner_q;
              found_d      = 1'b1;
            end
          end else if (!b_used_q && !found_q) begin
            found_d     = 1'b1;
            pick_slot_d = b_idx_q;
          end
        end
        if (!issue && !a_vld_q && !b_vld_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (can_emit) begin
          out_vld_d = 1'b1;
          if (faint_mode_q && found_q && (fv_q < cur_q.loud)) begin
            // evict the quietest occupant, the assign follows in ST_SECOND
            res_d = '{ACT_RETIRE, slot_out(pick_slot_q), src_out(pick_owner_q), '0, 1'b0};
            src_valid_d[pick_owner_q] = 1'b0;
            state_d = ST_SECOND;
          end else if (!faint_mode_q && found_q) begin
            take     = 1'b1;
            in_use_d = CNT_W'(in_use_q + 1'b1);
            state_d  = ST_IDLE;
          end else begin
            res_d   = '{ACT_NONE, '0, '0, '0, 1'b1};
            state_d = ST_IDLE;
          end
        end
      end

      ST_SECOND: begin
        if (can_emit) begin
          out_vld_d = 1'b1;
          take      = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (take) begin
      src_valid_d[cur_src]      = 1'b1;
      slot_valid_d[pick_slot_q] = 1'b1;
      sos_we                    = 1'b1;
      own_we                    = 1'b1;
      res_d = '{ACT_ASSIGN, slot_out(pick_slot_q), src_out(cur_src), '0, 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      src_valid_q  <= '0;
      slot_valid_q <= '0;
      in_use_q     <= '0;
      a_vld_q      <= 1'b0;
      b_vld_q      <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      src_valid_q  <= src_valid_d;
      slot_valid_q <= slot_valid_d;
      in_use_q     <= in_use_d;
      a_vld_q      <= a_vld_d;
      b_vld_q      <= b_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    faint_mode_q <= faint_mode_d;
    cnt_q        <= cnt_d;
    a_used_q     <= a_used_d;
    a_idx_q      <= a_idx_d;
    b_used_q     <= b_used_d;
    b_idx_q      <= b_idx_d;
    b_owner_q    <= b_owner_d;
    found_q      <= found_d;
    pick_slot_q  <= pick_slot_d;
    pick_owner_q <= pick_owner_d;
    fv_q         <= fv_d;
    res_q        <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign result_o    = res_q;

endmodule

// ===== rtl/vsa_checker.sv =====
// ----------------------------------------------------------------------------
// vsa_checker
// Port-level checks on the result channel of the voice slot allocator.
// ----------------------------------------------------------------------------
`include "voice_slot_allocator_macros.svh"

module vsa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] action_o,
  input logic [4:0] slot_o,
  input logic [5:0] source_o,
  input logic [2:0] forwarded_func_o,
  input logic       last_o
);
  import vsa_pkg::*;

  // hold a stalled result
  `VSA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(action_o) && $stable(slot_o) && $stable(source_o) && $stable(last_o))

  // an eviction retire is followed at once by an assign to the same slot
  `VSA_ASSERT_NXT(a_evict_pair, out_valid_o && out_ready_i && !last_o, out_valid_o && action_o == ACT_ASSIGN && last_o && slot_o == $past(slot_o))

  // only the retire of an eviction leaves an event open
  `VSA_ASSERT_IMP(a_open_is_retire, out_valid_o && !last_o, action_o == ACT_RETIRE)

  // no-action results carry zero fields; commands pass only on forward
  `VSA_ASSERT_IMP(a_none_clean, out_valid_o && action_o == ACT_NONE, slot_o == 5'd0 && source_o == 6'd0 && forwarded_func_o == 3'd0)
  `VSA_ASSERT_IMP(a_func_fwd_only, out_valid_o && action_o != ACT_FORWARD, forwarded_func_o == 3'd0)

endmodule

bind voice_slot_allocator vsa_checker u_vsa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .action_o         (action_o),
  .slot_o           (slot_o),
  .source_o         (source_o),
  .forwarded_func_o (forwarded_func_o),
  .last_o           (last_o)
);

// ===== bench/voice_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// voice_slot_allocator_tb
// Self-checking bench for the voice slot allocator. Event requests (source,
// loudness, command) go in over a valid/ready channel. A local copy of the
// slot tables works out the retire/assign/forward actions for each accepted
// request, and each result is compared against them in order. The run covers
// several slot limits, random idling on both sides, and long output stalls.
// ----------------------------------------------------------------------------
module voice_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsa_pkg::*;

  localparam int NUM_SLOTS     = 32;
  localparam int NUM_SOURCES   = 64;
  localparam int IDLE_PCT      = 15;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 48;
  localparam int HOLD_CYCLES   = 400;
  localparam int LIMIT_NS      = 1_000_000;

  localparam logic [FUNC_W-1:0] NO_FUNC = '0;

  typedef enum logic [FUNC_W-1:0] {
    CMD_PLAY,
    CMD_STOP,
    CMD_GAIN,
    CMD_LOOP,
    CMD_PITCH,
    CMD_POSITION,
    CMD_VELOCITY,
    CMD_NONE
  } cmd_e;

  typedef struct {
    action_e                 act;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [SRC_FIELD_W-1:0]  src;
    logic [FUNC_W-1:0]       fn;
    logic                    last;
  } slot_action_t;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    cfg_we_i       = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i    = '0;
  logic                    in_valid_i     = 1'b0;
  logic [SRC_FIELD_W-1:0]  source_index_i = '0;
  logic [LOUD_W-1:0]       loudness_i     = '0;
  logic [FUNC_W-1:0]       func_i         = '0;
  logic                    out_ready_i    = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [1:0]              action_o;
  logic [SLOT_FIELD_W-1:0] slot_o;
  logic [SRC_FIELD_W-1:0]  source_o;
  logic [FUNC_W-1:0]       forwarded_func_o;
  logic                    last_o;

  // Local copy of the allocation tables
  logic [LOUD_W-1:0]       src_loud   [NUM_SOURCES];
  logic                    src_held   [NUM_SOURCES];
  logic [SLOT_FIELD_W-1:0] src_slot   [NUM_SOURCES];
  logic                    slot_held  [NUM_SLOTS];
  logic [SRC_FIELD_W-1:0]  slot_owner [NUM_SLOTS];
  int                      held_count;
  int                      slots_avail;

  slot_action_t slot_actions_due[$];

  int errors         = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int evictions_seen = 0;
  bit steady         = 1'b0;
  bit rx_hold        = 1'b0;

  voice_slot_allocator #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_SOURCES(NUM_SOURCES)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .source_index_i  (source_index_i),
    .loudness_i      (loudness_i),
    .func_i          (func_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .action_o        (action_o),
    .slot_o          (slot_o),
    .source_o        (source_o),
    .forwarded_func_o(forwarded_func_o),
    .last_o          (last_o)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Allocation tables
  // --------------------------------------------------------------------------
  function automatic void clear_allocation();
    for (int s = 0; s < NUM_SOURCES; s++) begin
      src_loud[s] = '0;
      src_held[s] = 1'b0;
      src_slot[s] = '0;
    end
    for (int v = 0; v < NUM_SLOTS; v++) begin
      slot_held[v]  = 1'b0;
      slot_owner[v] = '0;
    end
    held_count  = 0;
    slots_avail = int'(SLOTS_AVAIL_RST);
  endfunction

  function automatic void push_action(action_e act, logic [SLOT_FIELD_W-1:0] slot,
                                      logic [SRC_FIELD_W-1:0] src,
                                      logic [FUNC_W-1:0] fn, logic last);
    slot_action_t a;
    a.act  = act;
    a.slot = slot;
    a.src  = src;
    a.fn   = fn;
    a.last = last;
    slot_actions_due.push_back(a);
  endfunction

  function automatic void release_voice(logic [SRC_FIELD_W-1:0] src);
    if (!src_held[src]) return;
    slot_held[src_slot[src]] = 1'b0;
    src_held[src] = 1'b0;
    if (held_count > 0) held_count--;
  endfunction

  function automatic void claim_voice(logic [SRC_FIELD_W-1:0] src, int slot);
    src_held[src]    = 1'b1;
    src_slot[src]    = SLOT_FIELD_W'(slot);
    slot_held[slot]  = 1'b1;
    slot_owner[slot] = src;
    held_count++;
  endfunction

  // Work out the actions one accepted request causes and update the tables
  function automatic void allocate_voice(logic [SRC_FIELD_W-1:0] src,
                                         logic [LOUD_W-1:0] loud_in,
                                         logic [FUNC_W-1:0] fn);
    logic [LOUD_W-1:0]      loud;
    logic [LOUD_W-1:0]      faint_loud;
    logic [SRC_FIELD_W-1:0] victim;
    int                     usable;
    int                     faint;
    loud   = (loud_in > LOUD_ONE) ? LOUD_ONE : loud_in;
    usable = (slots_avail < NUM_SLOTS) ? slots_avail : NUM_SLOTS;
    src_loud[src] = loud;
    if (loud == 0) begin
      if (src_held[src]) begin
        push_action(ACT_RETIRE, src_slot[src], src, NO_FUNC, 1'b1);
        release_voice(src);
      end else begin
        push_action(ACT_NONE, '0, '0, NO_FUNC, 1'b1);
      end
    end else if (src_held[src]) begin
      if (fn == CMD_NONE) push_action(ACT_NONE, '0, '0, NO_FUNC, 1'b1);
      else push_action(ACT_FORWARD, src_slot[src], src, fn, 1'b1);
    end else if (held_count < usable) begin
      faint = -1;
      for (int i = 0; i < usable; i++) begin
        if (!slot_held[i] && faint < 0) faint = i;
      end
      if (faint >= 0) begin
        claim_voice(src, faint);
        push_action(ACT_ASSIGN, SLOT_FIELD_W'(faint), src, NO_FUNC, 1'b1);
      end else begin
        push_action(ACT_NONE, '0, '0, NO_FUNC, 1'b1);
      end
    end else begin
      // Pool full: lowest usable slot with the smallest loudness below 1.0
      faint_loud = LOUD_ONE;
      faint      = 0;
      for (int i = 0; i < usable; i++) begin
        if (slot_held[i] && src_loud[slot_owner[i]] < faint_loud) begin
          faint_loud = src_loud[slot_owner[i]];
          faint      = i;
        end
      end
      if (faint_loud < loud) begin
        victim = slot_owner[faint];
        release_voice(victim);
        claim_voice(src, faint);
        push_action(ACT_RETIRE, SLOT_FIELD_W'(faint), victim, NO_FUNC, 1'b0);
        push_action(ACT_ASSIGN, SLOT_FIELD_W'(faint), src, NO_FUNC, 1'b1);
      end else begin
        push_action(ACT_NONE, '0, '0, NO_FUNC, 1'b1);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random ready, compare against the oldest expected action
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void take_result();
    slot_action_t want;
    if (slot_actions_due.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: expected none, actual action %0d slot %0d",
               $time, action_o, slot_o);
      return;
    end
    want = slot_actions_due.pop_front();
    results_seen++;
    if (want.act == ACT_RETIRE && !want.last) evictions_seen++;
    check_field("action", 8'(want.act), 8'(action_o));
    check_field("slot", 8'(want.slot), 8'(slot_o));
    check_field("source", 8'(want.src), 8'(source_o));
    check_field("forwarded_func", 8'(want.fn), 8'(forwarded_func_o));
    check_field("last", 8'(want.last), 8'(last_o));
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) take_result();
    if (rx_hold) out_ready_i <= 1'b0;
    else out_ready_i <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Called right after a rising edge; leaves valid high after acceptance
  task automatic send_request(logic [SRC_FIELD_W-1:0] src, logic [LOUD_W-1:0] loud,
                              logic [FUNC_W-1:0] fn);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    source_index_i <= src;
    loudness_i     <= loud;
    func_i         <= fn;
    do @(posedge clk_i); while (!in_ready_o);
    allocate_voice(src, loud, fn);
    requests_sent++;
  endtask

  task automatic send_random_request(int src_span);
    logic [LOUD_W-1:0] loud;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 12) loud = '0;
    else if (pick < 17) loud = LOUD_ONE;
    else if (pick < 22) loud = LOUD_W'($urandom_range(2**LOUD_W - 1, LOUD_ONE + 1));
    else if (pick < 35) loud = LOUD_W'($urandom_range(16, 1));
    else loud = LOUD_W'($urandom_range(LOUD_ONE - 1, 1));
    send_request(SRC_FIELD_W'($urandom_range(src_span - 1, 0)), loud,
                 FUNC_W'($urandom_range(7, 0)));
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (slot_actions_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_slots_available(logic [CFG_W-1:0] value);
    wait_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    slots_avail = int'(value);
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_silent_and_forward();
    write_slots_available(SLOTS_AVAIL_RST);
    send_request(0, 0, CMD_PLAY);                // silent with no slot
    send_request(0, LOUD_ONE, CMD_PLAY);         // lowest free slot
    send_request(0, 2**LOUD_W - 1, CMD_GAIN);    // saturated loudness
    send_request(0, 100, CMD_NONE);              // command none on a held slot
    send_request(63, 1, CMD_LOOP);
    send_request(63, 1, CMD_STOP);
    send_request(63, 1, CMD_PITCH);
    send_request(63, 1, CMD_POSITION);
    send_request(63, 1, CMD_VELOCITY);
    send_request(0, 0, CMD_PLAY);                // retire
    send_request(5, 500, CMD_PLAY);              // reuse the freed slot
  endtask

  task automatic test_pool_full();
    // One usable slot while a second one stays held above the limit
    write_slots_available(1);
    send_request(10, 400, CMD_PLAY);             // quieter than occupant
    send_request(10, 500, CMD_PLAY);             // equal: no eviction
    send_request(10, 501, CMD_PLAY);             // evict
    send_request(63, 2, CMD_PITCH);              // held slot above the limit
    send_request(10, LOUD_ONE, CMD_GAIN);
    send_request(11, LOUD_ONE, CMD_PLAY);        // every usable occupant at full scale
    send_request(63, 0, CMD_STOP);
    write_slots_available(0);
    send_request(20, LOUD_ONE, CMD_PLAY);        // nothing usable
    send_request(10, 0, CMD_STOP);
    send_request(10, 3, CMD_PLAY);
  endtask

  task automatic test_random_traffic(logic [CFG_W-1:0] avail, int count, int src_span);
    write_slots_available(avail);
    repeat (count) send_random_request(src_span);
  endtask

  task automatic test_steady_stream(int count);
    steady <= 1'b1;
    repeat (count) send_random_request(NUM_SOURCES);
    wait_drain();
    steady <= 1'b0;
  endtask

  task automatic test_output_stall(int count);
    // Hold the output off while requests keep coming, so the input stalls
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (count) send_random_request(40);
    wait_drain();
  endtask

  task automatic test_burst_pause(int bursts, int burst_len);
    repeat (bursts) begin
      repeat (burst_len) send_random_request(48);
      wait_drain();
    end
  endtask

  initial begin
    clear_allocation();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_silent_and_forward();
    test_pool_full();
    test_random_traffic(63, 150, 48);
    test_random_traffic(SLOTS_AVAIL_RST, 350, NUM_SOURCES);
    test_steady_stream(150);
    test_output_stall(40);
    test_random_traffic(4, 150, 12);
    test_random_traffic(1, 100, 8);
    test_random_traffic(0, 40, NUM_SOURCES);
    test_random_traffic(17, 150, 40);
    test_burst_pause(6, 10);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests, checked %0d results including %0d evictions,",
             requests_sent, results_seen, evictions_seen);
    $display("over slot limits 0, 1, 4, 17, 32 and 63 with idling and output stalls.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results still expected", slot_actions_due.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/vsa_pkg.sv
rtl/vsa_ram.sv
rtl/vsa_fifo.sv
rtl/vsa_front.sv
rtl/vsa_back.sv
rtl/voice_slot_allocator.sv
rtl/vsa_checker.sv
bench/voice_slot_allocator_tb.sv
